// ===== hw/rtl/asat_pkg.sv =====
// Shared types, constants and helpers for the active speaker aging table.
package asat_pkg;

  localparam int unsigned TableDepth = 16;
  localparam int unsigned MaxResults = 16;
  localparam int unsigned ResCntW    = $clog2(MaxResults + 1);
  localparam int unsigned TimeW      = 32;
  localparam int unsigned SourceW    = 32;
  localparam int unsigned TicksW     = 31;
  localparam int unsigned CfgIndexW  = 2;
  localparam int unsigned CfgDataW   = 32;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] RegNotifyEnable = 2'd0;
  localparam logic [CfgIndexW-1:0] RegGrayTicks    = 2'd1;
  localparam logic [CfgIndexW-1:0] RegRemoveTicks  = 2'd2;

  typedef enum logic [1:0] {
    OpMark  = 2'd0,
    OpTick  = 2'd1,
    OpLeave = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    NoteActivate   = 2'd0,
    NoteGray       = 2'd1,
    NoteDeactivate = 2'd2,
    NoteFull       = 2'd3
  } note_e;

  typedef enum logic [1:0] {
    StIdle,
    StWalk,
    StFinish,
    StFlush
  } state_e;

  typedef enum logic [1:0] {
    TblHold,
    TblRotate,
    TblRemove,
    TblInsert
  } tbl_op_e;

  typedef struct packed {
    logic [SourceW-1:0] source;
    logic [TimeW-1:0]   seen;
    logic               gray;
  } entry_t;

  typedef struct packed {
    tbl_op_e op;
    entry_t  ent;
  } tbl_ctrl_t;

  typedef struct packed {
    logic match;
    logic rem_hit;
    logic gray_hit;
  } cmp_t;

  // A wrapped difference means "later" when it is nonzero and below half the range.
  function automatic logic is_later(logic [TimeW-1:0] diff);
    return (diff != '0) && !diff[TimeW-1];
  endfunction

endpackage

// ===== hw/rtl/asat_table.sv =====
// Entry store kept newest first, walked by rotating its valid part through the head.
module asat_table #(
  parameter int unsigned Depth = asat_pkg::TableDepth,
  localparam int unsigned CntW = $clog2(Depth + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  asat_pkg::tbl_ctrl_t ctrl_i,
  output logic [CntW-1:0]     cnt_o,
  output asat_pkg::entry_t    head_o
);

  asat_pkg::entry_t ent_q [Depth];
  asat_pkg::entry_t up_w  [Depth];
  asat_pkg::entry_t dn_w  [Depth];
  logic [CntW-1:0]  cnt_q, cnt_d;

  always_comb begin
    for (int k = 0; k < Depth - 1; k++) begin
      up_w[k]     = ent_q[k+1];
      dn_w[k+1]   = ent_q[k];
    end
    up_w[Depth-1] = ent_q[Depth-1];
    dn_w[0]       = ent_q[0];
  end

  always_comb begin
    cnt_d = cnt_q;
    case (ctrl_i.op)
      asat_pkg::TblRemove: cnt_d = cnt_q - CntW'(1);
      asat_pkg::TblInsert: cnt_d = cnt_q + CntW'(1);
      default:             cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // The head leaves on each walk step; on a rotate it comes back at the last valid slot,
  // on a remove it does not, which closes the gap once the walk has gone all the way round.
  always_ff @(posedge clk_i) begin
    case (ctrl_i.op)
      asat_pkg::TblRotate: begin
        for (int k = 0; k < Depth; k++) begin
          if (CntW'(k + 1) == cnt_q) begin
            ent_q[k] <= ctrl_i.ent;
          end else if (CntW'(k + 1) < cnt_q) begin
            ent_q[k] <= up_w[k];
          end
        end
      end
      asat_pkg::TblRemove: begin
        for (int k = 0; k < Depth; k++) begin
          if (CntW'(k + 1) < cnt_q) begin
            ent_q[k] <= up_w[k];
          end
        end
      end
      asat_pkg::TblInsert: begin
        ent_q[0] <= ctrl_i.ent;
        for (int k = 1; k < Depth; k++) begin
          ent_q[k] <= dn_w[k];
        end
      end
      default: begin
      end
    endcase
  end

  assign cnt_o  = cnt_q;
  assign head_o = ent_q[0];

endmodule

// ===== hw/rtl/asat_age_cmp.sv =====
// Shared compare unit: source match and wrap-aware age checks on the head entry.
module asat_age_cmp (
  input  asat_pkg::entry_t                  head_i,
  input  logic [asat_pkg::SourceW-1:0]      key_source_i,
  input  logic [asat_pkg::TimeW-1:0]        now_rem_i,
  input  logic [asat_pkg::TimeW-1:0]        now_gray_i,
  output asat_pkg::cmp_t                    cmp_o
);

  logic [asat_pkg::TimeW-1:0] rem_diff;
  logic [asat_pkg::TimeW-1:0] gray_diff;

  // now_rem and now_gray already have the threshold taken off the current time.
  assign rem_diff  = now_rem_i - head_i.seen;
  assign gray_diff = now_gray_i - head_i.seen;

  assign cmp_o.match    = (head_i.source == key_source_i);
  assign cmp_o.rem_hit  = asat_pkg::is_later(rem_diff);
  assign cmp_o.gray_hit = asat_pkg::is_later(gray_diff);

endmodule

// ===== hw/rtl/active_speaker_aging_table_core.sv =====
// Top level: sequencer, configuration registers and notice output of the aging table.
// An item walks the table (N = table fill, at most TABLE_DEPTH) with one compare step
// per entry, then a finish and a flush state; an unused op code never raises busy.
// The next item is taken only while busy is low, so one item is through before the next.
// Notices leave at most one per cycle; the last appears in the same cycle as busy drops.
// Reset empties the table and loads notify 1, gray 480 and remove 24000 ticks.
module active_speaker_aging_table_core #(
  parameter int unsigned TABLE_DEPTH = asat_pkg::TableDepth
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        op_i,
  input  logic [asat_pkg::SourceW-1:0]      source_id_i,
  input  logic [asat_pkg::TimeW-1:0]        time_stamp_i,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [asat_pkg::CfgIndexW-1:0]    cfg_index_i,
  input  logic [asat_pkg::CfgDataW-1:0]     cfg_data_i,
  output logic                              result_valid_o,
  output logic [1:0]                        notice_o,
  output logic [asat_pkg::SourceW-1:0]      notice_source_o,
  output logic                              last_o
);

  localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

  // Configuration registers.
  logic                        notify_q;
  logic [asat_pkg::TicksW-1:0] gray_q;
  logic [asat_pkg::TicksW-1:0] remove_q;

  // Sequencer state and item operands.
  asat_pkg::state_e            state_q, state_d;
  asat_pkg::op_e               op_q, op_d;
  logic [asat_pkg::SourceW-1:0] src_q, src_d;
  logic [asat_pkg::TimeW-1:0]   time_q, time_d;
  logic [asat_pkg::TimeW-1:0]   nrem_q, nrem_d;
  logic [asat_pkg::TimeW-1:0]   ngray_q, ngray_d;
  logic [CntW-1:0]              rem_q, rem_d;
  logic                         found_q, found_d;
  logic                         done_q, done_d;

  // Notice path: one pending notice is held until it is known whether it is the last.
  logic [asat_pkg::ResCntW-1:0] res_cnt_q, res_cnt_d;
  logic                         pend_v_q, pend_v_d;
  asat_pkg::note_e              pend_note_q, pend_note_d;
  logic [asat_pkg::SourceW-1:0] pend_src_q, pend_src_d;
  logic                         out_v_q, out_v_d;
  asat_pkg::note_e              out_note_q, out_note_d;
  logic [asat_pkg::SourceW-1:0] out_src_q, out_src_d;
  logic                         out_last_q, out_last_d;

  logic                         new_v;
  asat_pkg::note_e              new_note;
  logic [asat_pkg::SourceW-1:0] new_src;
  logic                         take;
  logic                         accept;

  asat_pkg::tbl_ctrl_t          tbl_ctrl;
  logic [CntW-1:0]              tbl_cnt;
  asat_pkg::entry_t             head;
  asat_pkg::cmp_t               cmp;

  asat_table #(
    .Depth (TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (tbl_ctrl),
    .cnt_o  (tbl_cnt),
    .head_o (head)
  );

  asat_age_cmp u_cmp (
    .head_i       (head),
    .key_source_i (src_q),
    .now_rem_i    (nrem_q),
    .now_gray_i   (ngray_q),
    .cmp_o        (cmp)
  );

  assign accept      = start && (state_q == asat_pkg::StIdle);
  assign busy        = (state_q != asat_pkg::StIdle);
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      notify_q <= 1'b1;
      gray_q   <= asat_pkg::TicksW'(480);
      remove_q <= asat_pkg::TicksW'(24000);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        asat_pkg::RegNotifyEnable: notify_q <= cfg_data_i[0];
        asat_pkg::RegGrayTicks:    gray_q   <= cfg_data_i[asat_pkg::TicksW-1:0];
        asat_pkg::RegRemoveTicks:  remove_q <= cfg_data_i[asat_pkg::TicksW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: next state, table command and the notice raised this cycle.
  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    src_d    = src_q;
    time_d   = time_q;
    nrem_d   = nrem_q;
    ngray_d  = ngray_q;
    rem_d    = rem_q;
    found_d  = found_q;
    done_d   = done_q;
    new_v    = 1'b0;
    new_note = asat_pkg::NoteActivate;
    new_src  = head.source;
    tbl_ctrl.op  = asat_pkg::TblHold;
    tbl_ctrl.ent = head;

    case (state_q)
      asat_pkg::StIdle: begin
        if (accept) begin
          op_d    = asat_pkg::op_e'(op_i);
          src_d   = source_id_i;
          time_d  = time_stamp_i;
          nrem_d  = time_stamp_i - {1'b0, remove_q};
          ngray_d = time_stamp_i - {1'b0, gray_q};
          rem_d   = tbl_cnt;
          found_d = 1'b0;
          done_d  = 1'b0;
          if (op_i == asat_pkg::OpMark || op_i == asat_pkg::OpTick
              || op_i == asat_pkg::OpLeave) begin
            state_d = (tbl_cnt != '0) ? asat_pkg::StWalk : asat_pkg::StFinish;
          end
        end
      end

      asat_pkg::StWalk: begin
        tbl_ctrl.op = asat_pkg::TblRotate;
        case (op_q)
          asat_pkg::OpMark: begin
            if (!found_q && cmp.match) begin
              found_d           = 1'b1;
              tbl_ctrl.ent.seen = time_q;
              tbl_ctrl.ent.gray = 1'b0;
              if (head.gray) begin
                new_v    = notify_q;
                new_note = asat_pkg::NoteActivate;
              end
            end
          end
          asat_pkg::OpLeave: begin
            if (!found_q && cmp.match) begin
              found_d     = 1'b1;
              tbl_ctrl.op = asat_pkg::TblRemove;
              new_v       = notify_q;
              new_note    = asat_pkg::NoteDeactivate;
            end
          end
          asat_pkg::OpTick: begin
            // After the one removal the rest of the walk only restores the order.
            if (!done_q) begin
              if (cmp.rem_hit) begin
                done_d      = 1'b1;
                tbl_ctrl.op = asat_pkg::TblRemove;
                new_v       = notify_q;
                new_note    = asat_pkg::NoteDeactivate;
              end else if (cmp.gray_hit && !head.gray) begin
                tbl_ctrl.ent.gray = 1'b1;
                new_v             = notify_q;
                new_note          = asat_pkg::NoteGray;
              end
            end
          end
          default: begin
          end
        endcase
        rem_d = rem_q - CntW'(1);
        if (rem_q == CntW'(1)) begin
          state_d = asat_pkg::StFinish;
        end
      end

      asat_pkg::StFinish: begin
        if (op_q == asat_pkg::OpMark && !found_q) begin
          new_src = src_q;
          if (tbl_cnt == CntW'(TABLE_DEPTH)) begin
            new_v    = 1'b1;
            new_note = asat_pkg::NoteFull;
          end else begin
            tbl_ctrl.op          = asat_pkg::TblInsert;
            tbl_ctrl.ent.source  = src_q;
            tbl_ctrl.ent.seen    = time_q;
            tbl_ctrl.ent.gray    = 1'b0;
            new_v                = notify_q;
            new_note             = asat_pkg::NoteActivate;
          end
        end
        state_d = asat_pkg::StFlush;
      end

      asat_pkg::StFlush: begin
        state_d = asat_pkg::StIdle;
      end

      default: begin
        state_d = asat_pkg::StIdle;
      end
    endcase
  end

  assign take = new_v && (res_cnt_q < asat_pkg::ResCntW'(asat_pkg::MaxResults));

  always_comb begin
    res_cnt_d   = res_cnt_q;
    pend_v_d    = pend_v_q;
    pend_note_d = pend_note_q;
    pend_src_d  = pend_src_q;
    out_v_d     = 1'b0;
    out_note_d  = out_note_q;
    out_src_d   = out_src_q;
    out_last_d  = out_last_q;
    if (accept) begin
      res_cnt_d = '0;
    end
    if (take) begin
      res_cnt_d   = res_cnt_q + asat_pkg::ResCntW'(1);
      pend_v_d    = 1'b1;
      pend_note_d = new_note;
      pend_src_d  = new_src;
      if (pend_v_q) begin
        out_v_d    = 1'b1;
        out_note_d = pend_note_q;
        out_src_d  = pend_src_q;
        out_last_d = 1'b0;
      end
    end else if (state_q == asat_pkg::StFlush && pend_v_q) begin
      pend_v_d   = 1'b0;
      out_v_d    = 1'b1;
      out_note_d = pend_note_q;
      out_src_d  = pend_src_q;
      out_last_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= asat_pkg::StIdle;
      pend_v_q  <= 1'b0;
      out_v_q   <= 1'b0;
      res_cnt_q <= '0;
      found_q   <= 1'b0;
      done_q    <= 1'b0;
      rem_q     <= '0;
    end else begin
      state_q   <= state_d;
      pend_v_q  <= pend_v_d;
      out_v_q   <= out_v_d;
      res_cnt_q <= res_cnt_d;
      found_q   <= found_d;
      done_q    <= done_d;
      rem_q     <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    src_q       <= src_d;
    time_q      <= time_d;
    nrem_q      <= nrem_d;
    ngray_q     <= ngray_d;
    pend_note_q <= pend_note_d;
    pend_src_q  <= pend_src_d;
    out_note_q  <= out_note_d;
    out_src_q   <= out_src_d;
    out_last_q  <= out_last_d;
  end

  assign result_valid_o  = out_v_q;
  assign notice_o        = out_note_q;
  assign notice_source_o = out_src_q;
  assign last_o          = out_last_q;

endmodule
